// ----- sv/pruf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pruf_pkg
// Shared types, constants and helpers for the Pruefer sequence decoder.
// ----------------------------------------------------------------------------
package pruf_pkg;

  localparam int CODE_W        = 6;
  localparam int DEF_MAX_NODES = 64;
  localparam int MASK_W        = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int LEVEL_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CODE_W-1:0] DEG_MAX = '1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic loading;
    logic decoding;
  } back_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_PRIME,
    BK_FETCH,
    BK_EMIT,
    BK_FIN_A,
    BK_FIN_B
  } back_state_t;

  function automatic logic [CODE_W-1:0] lowest_one(input logic [MASK_W-1:0] m);
    logic [CODE_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) idx = CODE_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pruf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pruf_in_if / pruf_out_if
// Valid/ready channels for code words in and tree edges out.
// ----------------------------------------------------------------------------
interface pruf_in_if import pruf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_entry;
  logic              last_entry;

  modport source (output valid, output code_entry, output last_entry, input ready);
  modport sink   (input valid, input code_entry, input last_entry, output ready);
endinterface

interface pruf_out_if import pruf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] edge_first;
  logic [CODE_W-1:0] edge_second;
  logic              last_edge;
  logic              bad_sequence;

  modport source (output valid, output edge_first, output edge_second,
                  output last_edge, output bad_sequence, input ready);
  modport sink   (input valid, input edge_first, input edge_second,
                  input last_edge, input bad_sequence, output ready);
endinterface
`default_nettype wire

// ----- sv/pruf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pruf_front
// Input side: takes code words and tags each with its node range check.
// ----------------------------------------------------------------------------
module pruf_front import pruf_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  pruf_in_if.sink code,
  output logic    push_valid,
  input  logic    push_ready,
  output cmd_t    push_word
);

  assign code.ready         = push_ready;
  assign push_valid         = code.valid;
  assign push_word.code     = code.code_entry;
  assign push_word.last     = code.last_entry;
  assign push_word.in_range = int'(code.code_entry) < MAX_NODES;

endmodule
`default_nettype wire

// ----- sv/pruf_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pruf_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module pruf_queue import pruf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  cmd_t               push_word,
  output logic               pop_valid,
  input  logic               pop,
  output cmd_t               pop_word,
  output logic [LEVEL_W-1:0] level
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic             do_push;
  logic             do_pop;

  assign push_ready = level != LEVEL_W'(QUEUE_DEPTH);
  assign pop_valid  = level != '0;
  assign pop_word   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop)      level <= level + 1'b1;
      else if (do_pop && !do_push) level <= level - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pruf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pruf_back
// Execution side: stores the sequence, keeps degrees, decodes the edges.
// ----------------------------------------------------------------------------
module pruf_back import pruf_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  cmd_t         q_word,
  output logic         q_pop,
  output back_status_t status,
  pruf_out_if.source   edges
);

  localparam int STORE_DEPTH = MAX_NODES - 2;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES - 1);
  localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  back_state_t state, state_next;

  logic [CODE_W-1:0]    seq_mem [STORE_DEPTH];
  logic [CODE_W-1:0]    seq_rdata;
  logic                 seq_we, seq_re;
  logic [SIDX_W-1:0]    seq_waddr, seq_raddr;
  logic [CODE_W-1:0]    seq_wdata;

  logic [CODE_W-1:0]    deg_mem [MAX_NODES];
  logic [CODE_W-1:0]    deg_rdata;
  logic                 deg_we, deg_re;
  logic [NODE_W-1:0]    deg_waddr, deg_raddr;
  logic [CODE_W-1:0]    deg_wdata;

  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     pos, pos_next;
  logic                 err, err_next;
  logic [CODE_W-1:0]    maxc, maxc_next;
  logic [MAX_NODES-1:0] leaf, leaf_next;
  logic [MAX_NODES-1:0] occ, occ_next;
  logic                 pend_last, pend_next;
  logic [NODE_W-1:0]    ld_addr, ld_next;
  logic                 bad, bad_next;
  logic [CODE_W-1:0]    first_leaf, fl_next;

  logic                 out_valid, ov_next;
  logic [CODE_W-1:0]    o_first, o_first_next;
  logic [CODE_W-1:0]    o_second, o_second_next;
  logic                 o_last, o_last_next;
  logic                 o_bad, o_bad_next;

  assign edges.valid        = out_valid;
  assign edges.edge_first   = o_first;
  assign edges.edge_second  = o_second;
  assign edges.last_edge    = o_last;
  assign edges.bad_sequence = o_bad;

  assign status.loading  = state == BK_LOAD;
  assign status.decoding = state inside {BK_PRIME, BK_FETCH, BK_EMIT, BK_FIN_A, BK_FIN_B};

  always_ff @(posedge clk) begin
    if (seq_we) seq_mem[seq_waddr] <= seq_wdata;
    if (seq_re) seq_rdata <= seq_mem[seq_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (deg_re) deg_rdata <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      err       <= 1'b0;
      maxc      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      err       <= err_next;
      maxc      <= maxc_next;
      occ       <= occ_next;
      out_valid <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    leaf       <= leaf_next;
    pend_last  <= pend_next;
    ld_addr    <= ld_next;
    bad        <= bad_next;
    first_leaf <= fl_next;
    o_first    <= o_first_next;
    o_second   <= o_second_next;
    o_last     <= o_last_next;
    o_bad      <= o_bad_next;
  end

  always_comb begin
    logic                 out_free;
    logic                 fresh;
    logic                 full;
    logic                 err_base;
    logic [CODE_W-1:0]    maxc_base;
    logic [MAX_NODES-1:0] lm;
    logic [CODE_W-1:0]    lw;
    logic [CODE_W-1:0]    dsel;
    logic [CODE_W-1:0]    par;
    logic                 p_in;
    logic [CNT_W-1:0]     pos_inc;
    logic [CODE_W:0]      nodes;

    out_free  = !out_valid || edges.ready;
    fresh     = count == '0;
    full      = count == CNT_W'(STORE_DEPTH);
    err_base  = fresh ? 1'b0 : err;
    maxc_base = fresh ? '0 : maxc;
    lm        = leaf;
    lw        = lowest_one(MASK_W'(leaf));
    par       = seq_rdata;
    p_in      = int'(par) < MAX_NODES;
    dsel      = occ[par[NODE_W-1:0]] ? deg_rdata : CODE_W'(1);
    pos_inc   = pos + 1'b1;
    nodes     = (CODE_W + 1)'(count) + (CODE_W + 1)'(2);

    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    err_next      = err;
    maxc_next     = maxc;
    leaf_next     = leaf;
    occ_next      = occ;
    pend_next     = pend_last;
    ld_next       = ld_addr;
    bad_next      = bad;
    fl_next       = first_leaf;
    ov_next       = out_valid && !edges.ready;
    o_first_next  = o_first;
    o_second_next = o_second;
    o_last_next   = o_last;
    o_bad_next    = o_bad;
    q_pop         = 1'b0;
    seq_we        = 1'b0;
    seq_waddr     = count[SIDX_W-1:0];
    seq_wdata     = q_word.code;
    seq_re        = 1'b0;
    seq_raddr     = '0;
    deg_we        = 1'b0;
    deg_waddr     = ld_addr;
    deg_wdata     = '0;
    deg_re        = 1'b0;
    deg_raddr     = q_word.code[NODE_W-1:0];

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          err_next  = err_base;
          maxc_next = maxc_base;
          if (fresh) occ_next = '0;
          if (!full) begin
            seq_we     = 1'b1;
            count_next = count + 1'b1;
            if (q_word.code > maxc_base) maxc_next = q_word.code;
          end
          if (!full && q_word.in_range) begin
            deg_re     = 1'b1;
            ld_next    = q_word.code[NODE_W-1:0];
            pend_next  = q_word.last;
            state_next = BK_LOAD;
          end else begin
            err_next = 1'b1;
            if (q_word.last) state_next = BK_PRIME;
          end
        end
      end
      BK_LOAD: begin
        deg_we = 1'b1;
        if (!occ[ld_addr])          deg_wdata = CODE_W'(2);
        else if (deg_rdata == DEG_MAX) deg_wdata = deg_rdata;
        else                        deg_wdata = deg_rdata + 1'b1;
        occ_next[ld_addr] = 1'b1;
        state_next = pend_last ? BK_PRIME : BK_IDLE;
      end
      BK_PRIME: begin
        for (int i = 0; i < MAX_NODES; i++) begin
          leaf_next[i] = !occ[i] && (i < int'(nodes));
        end
        bad_next   = err || ({1'b0, maxc} >= nodes);
        seq_re     = 1'b1;
        seq_raddr  = '0;
        pos_next   = '0;
        state_next = BK_FETCH;
      end
      BK_FETCH: begin
        deg_re     = 1'b1;
        deg_raddr  = par[NODE_W-1:0];
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          lm[lw[NODE_W-1:0]] = 1'b0;
          if (p_in && dsel > CODE_W'(1)) begin
            deg_we    = 1'b1;
            deg_waddr = par[NODE_W-1:0];
            deg_wdata = dsel - 1'b1;
            if (dsel == CODE_W'(2) && {1'b0, par} < nodes) lm[par[NODE_W-1:0]] = 1'b1;
          end
          leaf_next     = lm;
          ov_next       = 1'b1;
          o_first_next  = lw;
          o_second_next = par;
          o_last_next   = 1'b0;
          o_bad_next    = bad;
          pos_next      = pos_inc;
          if (pos_inc == count) begin
            state_next = BK_FIN_A;
          end else begin
            seq_re     = 1'b1;
            seq_raddr  = pos_inc[SIDX_W-1:0];
            state_next = BK_FETCH;
          end
        end
      end
      BK_FIN_A: begin
        lm[lw[NODE_W-1:0]] = 1'b0;
        leaf_next  = lm;
        fl_next    = lw;
        state_next = BK_FIN_B;
      end
      BK_FIN_B: begin
        if (out_free) begin
          ov_next       = 1'b1;
          o_first_next  = first_leaf;
          o_second_next = lw;
          o_last_next   = 1'b1;
          o_bad_next    = bad;
          count_next    = '0;
          state_next    = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/pruefer_code_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pruefer_code_decoder
// Rebuilds the edges of a labeled tree from its Pruefer sequence.
// ----------------------------------------------------------------------------
// Feed the sequence one code word per item, last_entry high on the final one;
// the tree has entry count plus two nodes. Each in-range entry is a read, then
// a write of the degree table in the back end (a memory with one write port and
// one registered read port). After the last entry the decoder builds the leaf
// set, then for each edge fetches the parent's degree, then emits and updates,
// and for the final edge takes the first leaf, then emits; the emit steps wait
// while the output is stalled. A two-entry queue lets input words arrive while
// the back end is busy. The sequence store and the degree table are never
// cleared: per-node occupancy bits mark which degrees are live, so there is no
// clearing pass after reset. bad_sequence is set on every edge when an entry
// was not below the node count or the store overflowed.
// ----------------------------------------------------------------------------
module pruefer_code_decoder import pruf_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic       clk,
  input  logic       rst,
  pruf_in_if.sink    code,
  pruf_out_if.source edges
);

  logic               push_valid;
  logic               push_ready;
  cmd_t               push_word;
  logic               q_valid;
  logic               q_pop;
  cmd_t               q_word;
  logic [LEVEL_W-1:0] q_level;
  back_status_t       back_st;

  pruf_front #(.MAX_NODES(MAX_NODES)) u_front (
    .code       (code),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  pruf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_word   (q_word),
    .level      (q_level)
  );

  pruf_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .status  (back_st),
    .edges   (edges)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_pop_in_load: assert property (@(posedge clk) disable iff (rst)
    back_st.loading |-> !q_pop)
    else $error("queue popped during degree update");

  a_decode_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    back_st.decoding && edges.valid && !edges.ready |=> back_st.decoding)
    else $error("decode left while output stalled");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_level == LEVEL_W'(QUEUE_DEPTH) |-> !code.ready)
    else $error("input ready with queue full");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !edges.valid)
    else $error("edge valid right after reset");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives Pruefer sequences into pruefer_code_decoder and checks every tree
// edge against a local decoder model. A short table of hand-picked sequences
// runs first, some rows carrying their first edge written out. Random
// sequences follow: mostly well-formed, some noisy, some with out-of-range
// entries or store overflow. Both channels idle at random, the edge side
// holds off once for a long stretch, and the code side drains once midway.
// ----------------------------------------------------------------------------
module testbench;
  import pruf_pkg::*;

  localparam int MAX_NODES      = DEF_MAX_NODES;
  localparam int STORE_DEPTH    = MAX_NODES - 2;
  localparam int NUM_PLAN       = 19;
  localparam int RANDOM_WORDS   = 320;
  localparam int HOLD_AT_EDGE   = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 11;

  typedef enum int {SEQ_CLEAN, SEQ_NOISE, SEQ_BROKEN} seq_kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
    logic              last;
    logic              bad;
  } tree_edge_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              typed;
    tree_edge_t        first_edge;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pruf_in_if  word_ch ();
  pruf_out_if edge_ch ();

  pruefer_code_decoder #(.MAX_NODES(MAX_NODES)) DUT (
    .clk   (clk),
    .rst   (rst),
    .code  (word_ch),
    .edges (edge_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CODE_W-1:0] seq_mem [STORE_DEPTH];
  logic [CODE_W-1:0] deg_tab [MAX_NODES];
  logic [MASK_W-1:0] leaf_set;
  int unsigned       n_held;
  logic              err_flag;

  tree_edge_t pending_edges [$];
  plan_row_t  plan [NUM_PLAN];
  int         words_taken;
  int         results_seen;
  int         errors;
  int         idle_cycles;
  int         sender_calm;
  int         receiver_calm;
  tree_edge_t got_edge;
  tree_edge_t want_edge;

  function automatic logic [CODE_W-1:0] pop_leaf();
    for (int i = 0; i < MASK_W; i++) begin
      if (leaf_set[i]) begin
        leaf_set[i] = 1'b0;
        return CODE_W'(i);
      end
    end
    return '0;
  endfunction

  task automatic decode_word(input logic [CODE_W-1:0] c, input logic l);
    int unsigned       nodes;
    logic              bad;
    logic [CODE_W-1:0] parent;
    logic [CODE_W-1:0] lf;
    logic [CODE_W-1:0] lf2;
    tree_edge_t        e_out;
    if (n_held == 0) begin
      foreach (deg_tab[i]) deg_tab[i] = 1;
      leaf_set = '0;
      err_flag = 1'b0;
    end
    if (n_held < STORE_DEPTH) begin
      seq_mem[n_held] = c;
      n_held++;
      if (deg_tab[c] < DEG_MAX) deg_tab[c]++;
    end else begin
      err_flag = 1'b1;
    end
    if (!l) return;
    nodes = n_held + 2;
    bad = err_flag;
    for (int i = 0; i < n_held; i++) begin
      if (seq_mem[i] >= nodes) bad = 1'b1;
    end
    leaf_set = '0;
    for (int i = 0; i < nodes && i < MAX_NODES; i++) begin
      if (deg_tab[i] == 1) leaf_set[i] = 1'b1;
    end
    for (int i = 0; i < n_held; i++) begin
      parent = seq_mem[i];
      lf = pop_leaf();
      e_out = '{lf, parent, 1'b0, bad};
      pending_edges = {pending_edges, e_out};
      if (deg_tab[parent] > 1) begin
        deg_tab[parent]--;
        if (deg_tab[parent] == 1 && parent < nodes) leaf_set[parent] = 1'b1;
      end
    end
    lf = pop_leaf();
    lf2 = pop_leaf();
    e_out = '{lf, lf2, 1'b1, bad};
    pending_edges = {pending_edges, e_out};
    n_held = 0;
  endtask

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic plan_row_t plan_row(input logic [CODE_W-1:0] c, input logic l,
                                         input logic typed, input logic [CODE_W-1:0] a,
                                         input logic [CODE_W-1:0] b, input logic bad);
    plan_row_t r;
    r.code = c;
    r.last = l;
    r.typed = typed;
    r.first_edge = '{a, b, 1'b0, bad};
    return r;
  endfunction

  task automatic put_word(input logic [CODE_W-1:0] c, input logic l);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      word_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_ch.valid      <= 1'b1;
    word_ch.code_entry <= c;
    word_ch.last_entry <= l;
    do @(posedge clk); while (!word_ch.ready);
  endtask

  task automatic wait_for_edges();
    word_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_edges.size() != 0) @(posedge clk);
  endtask

  task automatic report_miss(input logic found, input tree_edge_t want,
                             input tree_edge_t got);
    errors++;
    if (errors <= 10) begin
      if (found)
        $display("edge %0d: expected %0d-%0d last=%0b bad=%0b, got %0d-%0d last=%0b bad=%0b",
                 results_seen, want.first, want.second, want.last, want.bad,
                 got.first, got.second, got.last, got.bad);
      else
        $display("edge %0d: unexpected %0d-%0d last=%0b bad=%0b",
                 results_seen, got.first, got.second, got.last, got.bad);
    end
  endtask

  // predict on every accepted word
  always @(posedge clk) begin
    int base;
    if (!rst && word_ch.valid && word_ch.ready) begin
      base = pending_edges.size();
      decode_word(word_ch.code_entry, word_ch.last_entry);
      if (words_taken < NUM_PLAN && plan[words_taken].typed)
        pending_edges[base] = plan[words_taken].first_edge;
      words_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && edge_ch.valid && edge_ch.ready) begin
      got_edge = '{edge_ch.edge_first, edge_ch.edge_second,
                   edge_ch.last_edge, edge_ch.bad_sequence};
      if (pending_edges.size() == 0) begin
        report_miss(1'b0, got_edge, got_edge);
      end else begin
        want_edge = pending_edges.pop_front();
        if (got_edge != want_edge) report_miss(1'b1, want_edge, got_edge);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (word_ch.valid && word_ch.ready) || (edge_ch.valid && edge_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  gap;
    logic hold_done;
    hold_done = 1'b0;
    receiver_calm = 0;
    edge_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AT_EDGE) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = draw_gap(receiver_calm);
      end
      if (gap > 0) begin
        edge_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      edge_ch.ready <= 1'b1;
      do @(posedge clk); while (!edge_ch.valid);
    end
  end

  initial begin
    int                seq_no;
    int                n;
    int                hi;
    int                j;
    int                items_sent;
    seq_kind_t         kind;
    logic [CODE_W-1:0] v;
    word_ch.valid      <= 1'b0;
    word_ch.code_entry <= '0;
    word_ch.last_entry <= 1'b0;
    n_held = 0;
    err_flag = 1'b0;
    leaf_set = '0;
    words_taken = 0;
    results_seen = 0;
    errors = 0;
    idle_cycles = 0;
    sender_calm = 0;

    plan[0]  = plan_row(0,  1, 1, 1, 0,  0);
    plan[1]  = plan_row(63, 1, 1, 0, 63, 1);
    plan[2]  = plan_row(2,  1, 1, 0, 2,  0);
    plan[3]  = plan_row(3,  1, 1, 0, 3,  1);
    plan[4]  = plan_row(3,  0, 0, 0, 0,  0);
    plan[5]  = plan_row(3,  1, 1, 0, 3,  0);
    plan[6]  = plan_row(4,  0, 0, 0, 0,  0);
    plan[7]  = plan_row(4,  0, 0, 0, 0,  0);
    plan[8]  = plan_row(4,  1, 1, 0, 4,  0);
    plan[9]  = plan_row(42, 0, 0, 0, 0,  0);
    plan[10] = plan_row(21, 1, 1, 0, 42, 1);
    plan[11] = plan_row(1,  0, 0, 0, 0,  0);
    plan[12] = plan_row(0,  1, 1, 2, 1,  0);
    plan[13] = plan_row(5,  0, 0, 0, 0,  0);
    plan[14] = plan_row(5,  0, 0, 0, 0,  0);
    plan[15] = plan_row(0,  0, 0, 0, 0,  0);
    plan[16] = plan_row(1,  1, 0, 0, 0,  0);
    plan[17] = plan_row(63, 0, 0, 0, 0,  0);
    plan[18] = plan_row(0,  1, 0, 0, 0,  0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_PLAN; i++) put_word(plan[i].code, plan[i].last);

    // drain before the random part
    wait_for_edges();

    items_sent = 0;
    seq_no = 0;
    while (items_sent < RANDOM_WORDS) begin
      if (seq_no == 3) begin
        n = STORE_DEPTH;
      end else if (seq_no == 7) begin
        n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
      end else begin
        hi = $urandom_range(0, 99);
        if (hi < 85) n = $urandom_range(1, 8);
        else if (hi < 97) n = $urandom_range(9, 30);
        else n = $urandom_range(31, STORE_DEPTH);
      end
      hi = $urandom_range(0, 99);
      if (hi < 80) kind = SEQ_CLEAN;
      else if (hi < 92) kind = SEQ_NOISE;
      else kind = SEQ_BROKEN;
      j = $urandom_range(0, n - 1);
      hi = (n + 1 > MAX_NODES - 1) ? MAX_NODES - 1 : n + 1;
      for (int i = 0; i < n; i++) begin
        if (kind == SEQ_NOISE) v = CODE_W'($urandom_range(0, MAX_NODES - 1));
        else v = CODE_W'($urandom_range(0, hi));
        if (kind == SEQ_BROKEN && i == j && n + 2 <= MAX_NODES - 1)
          v = CODE_W'($urandom_range(n + 2, MAX_NODES - 1));
        put_word(v, i == n - 1);
        items_sent++;
      end
      seq_no++;
    end

    wait_for_edges();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
